@@ sv/tre_pkg.sv @@
`default_nettype none
package tre_pkg;

  // operation codes
  localparam logic [4:0] OP_NOP  = 5'd0;
  localparam logic [4:0] OP_LI   = 5'd1;
  localparam logic [4:0] OP_EXIT = 5'd2;
  localparam logic [4:0] OP_J    = 5'd3;
  localparam logic [4:0] OP_BEQ  = 5'd4;
  localparam logic [4:0] OP_ADD  = 5'd5;
  localparam logic [4:0] OP_ADDI = 5'd6;
  localparam logic [4:0] OP_SUB  = 5'd7;
  localparam logic [4:0] OP_SUBI = 5'd8;
  localparam logic [4:0] OP_MUL  = 5'd9;
  localparam logic [4:0] OP_AND  = 5'd10;
  localparam logic [4:0] OP_OR   = 5'd11;
  localparam logic [4:0] OP_SLL  = 5'd12;
  localparam logic [4:0] OP_SRL  = 5'd13;
  localparam logic [4:0] OP_MV   = 5'd14;
  localparam logic [4:0] OP_LW   = 5'd15;
  localparam logic [4:0] OP_LA   = 5'd16;
  localparam logic [4:0] OP_SW   = 5'd17;

  // execute unit functions
  localparam logic [3:0] ALU_IMM  = 4'd0;
  localparam logic [3:0] ALU_ADD  = 4'd1;
  localparam logic [3:0] ALU_SUB  = 4'd2;
  localparam logic [3:0] ALU_MUL  = 4'd3;
  localparam logic [3:0] ALU_AND  = 4'd4;
  localparam logic [3:0] ALU_OR   = 4'd5;
  localparam logic [3:0] ALU_SLL  = 4'd6;
  localparam logic [3:0] ALU_SRA  = 4'd7;
  localparam logic [3:0] ALU_MOV  = 4'd8;
  localparam logic [3:0] ALU_LOAD = 4'd9;

  localparam logic [4:0] HALT_REG = 5'd31;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = 1;

  typedef struct packed {
    logic [4:0]         operation;
    logic [4:0]         first_reg;
    logic [4:0]         second_reg;
    logic [4:0]         third_reg;
    logic signed [31:0] immediate;
    logic [9:0]         jump_target;
  } tre_in_t;

  typedef struct packed {
    logic [9:0]         next_pc;
    logic               reg_write;
    logic [4:0]         reg_index;
    logic signed [31:0] reg_value;
    logic               mem_write;
    logic [9:0]         mem_address;
    logic signed [31:0] mem_value;
    logic               halted;
  } tre_out_t;

  // decoded item as it sits in the queue
  typedef struct packed {
    logic [3:0]  alu;
    logic        use_imm;
    logic        rf_we;
    logic        is_lw;
    logic        is_sw;
    logic        is_j;
    logic        is_beq;
    logic [4:0]  dst;
    logic [4:0]  ra;
    logic [4:0]  rb;
    logic [31:0] imm;
    logic [9:0]  tgt;
  } tre_uop_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tre_q_stat_t;

  typedef struct packed {
    logic clearing;
    logic idle;
  } tre_bk_stat_t;

  // 10-bit value modulo m by restoring compare-subtract
  function automatic logic [9:0] pc_reduce(input logic [9:0] v, input logic [16:0] m);
    logic [16:0] r;
    r = '0;
    for (int i = 9; i >= 0; i--) begin
      r = {r[15:0], v[i]};
      if (r >= m) begin
        r = r - m;
      end
    end
    return r[9:0];
  endfunction

endpackage
`default_nettype wire

@@ sv/tre_front.sv @@
`default_nettype none
module tre_front import tre_pkg::*; #(
  parameter int unsigned PROG_WORDS = 1024
) (
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire tre_in_t     in_data,
  input  wire tre_q_stat_t q_stat,
  output logic             q_push,
  output tre_uop_t         q_din
);

  assign in_ready = !q_stat.full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_din         = '0;
    q_din.dst     = in_data.first_reg;
    q_din.ra      = in_data.second_reg;
    q_din.rb      = in_data.third_reg;
    q_din.imm     = in_data.immediate;
    q_din.tgt     = pc_reduce(in_data.jump_target, 17'(PROG_WORDS));
    case (in_data.operation)
      OP_LI, OP_LA: begin
        q_din.rf_we = 1'b1;
        q_din.alu   = ALU_IMM;
      end
      OP_EXIT: begin
        q_din.rf_we = 1'b1;
        q_din.alu   = ALU_IMM;
        q_din.dst   = HALT_REG;
        q_din.imm   = 32'd1;
      end
      OP_J: q_din.is_j = 1'b1;
      OP_BEQ: begin
        // compare first_reg against second_reg
        q_din.is_beq = 1'b1;
        q_din.rb     = in_data.first_reg;
      end
      OP_ADD, OP_ADDI: begin
        q_din.rf_we   = 1'b1;
        q_din.alu     = ALU_ADD;
        q_din.use_imm = (in_data.operation == OP_ADDI);
      end
      OP_SUB, OP_SUBI: begin
        q_din.rf_we   = 1'b1;
        q_din.alu     = ALU_SUB;
        q_din.use_imm = (in_data.operation == OP_SUBI);
      end
      OP_MUL: begin
        q_din.rf_we = 1'b1;
        q_din.alu   = ALU_MUL;
      end
      OP_AND: begin
        q_din.rf_we = 1'b1;
        q_din.alu   = ALU_AND;
      end
      OP_OR: begin
        q_din.rf_we = 1'b1;
        q_din.alu   = ALU_OR;
      end
      OP_SLL: begin
        q_din.rf_we = 1'b1;
        q_din.alu   = ALU_SLL;
      end
      OP_SRL: begin
        q_din.rf_we = 1'b1;
        q_din.alu   = ALU_SRA;
      end
      OP_MV: begin
        q_din.rf_we = 1'b1;
        q_din.alu   = ALU_MOV;
      end
      OP_LW: begin
        q_din.rf_we = 1'b1;
        q_din.is_lw = 1'b1;
        q_din.alu   = ALU_LOAD;
      end
      OP_SW: begin
        // store data comes through port A
        q_din.is_sw = 1'b1;
        q_din.ra    = in_data.first_reg;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ sv/tre_fifo.sv @@
`default_nettype none
module tre_fifo import tre_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire tre_uop_t din,
  input  wire logic     pop,
  output tre_uop_t      dout,
  output tre_q_stat_t   stat
);

  tre_uop_t          ent_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r;
  logic [Q_AW-1:0]   rd_ptr_r;
  logic [Q_AW:0]     cnt_r;
  logic [Q_AW:0]     cnt_nxt;

  assign stat.full  = (cnt_r == (Q_AW + 1)'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign dout       = ent_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= din;
    end
  end

endmodule
`default_nettype wire

@@ sv/tre_mod.sv @@
`default_nettype none
module tre_mod import tre_pkg::*; #(
  parameter int unsigned MOD = 1024,
  localparam int unsigned RW = $clog2(MOD)
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] value,
  output logic             done,
  output logic [RW-1:0]    result
);

  localparam bit IS_POW2 = ((MOD & (MOD - 1)) == 0);

  generate
    if (IS_POW2) begin : g_mask
      logic          done_r;
      logic [RW-1:0] res_r;

      assign done   = done_r;
      assign result = res_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          res_r <= value[RW-1:0];
        end
      end
    end else begin : g_serial
      // restoring reduction, eight bits per cycle
      localparam int unsigned STEPS  = 8;
      localparam int unsigned CYCLES = 32 / STEPS;
      localparam int unsigned CW     = $clog2(CYCLES);
      localparam logic [RW:0] MODV   = (RW + 1)'(MOD);

      logic          busy_r;
      logic          done_r;
      logic [CW-1:0] cnt_r;
      logic [31:0]   val_r;
      logic [RW:0]   rem_r;
      logic [RW:0]   rem_nxt;

      assign done   = done_r;
      assign result = rem_r[RW-1:0];

      always_comb begin
        rem_nxt = rem_r;
        for (int i = 0; i < STEPS; i++) begin
          rem_nxt = {rem_nxt[RW-1:0], val_r[31 - i]};
          if (rem_nxt >= MODV) begin
            rem_nxt = rem_nxt - MODV;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          busy_r <= 1'b0;
          done_r <= 1'b0;
          cnt_r  <= '0;
        end else begin
          done_r <= 1'b0;
          if (start) begin
            busy_r <= 1'b1;
            cnt_r  <= '0;
          end else if (busy_r) begin
            cnt_r <= cnt_r + 1'b1;
            if (cnt_r == CW'(CYCLES - 1)) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          val_r <= value;
          rem_r <= '0;
        end else if (busy_r) begin
          val_r <= val_r << STEPS;
          rem_r <= rem_nxt;
        end
      end
    end
  endgenerate

endmodule
`default_nettype wire

@@ sv/tre_back.sv @@
`default_nettype none
module tre_back import tre_pkg::*; #(
  parameter int unsigned MEM_WORDS  = 1024,
  parameter int unsigned PROG_WORDS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [9:0]  cfg_wdata,
  input  wire tre_q_stat_t q_stat,
  input  wire tre_uop_t    q_dout,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output tre_out_t         out_data,
  output tre_bk_stat_t     bk_stat
);

  localparam int unsigned MEM_AW = $clog2(MEM_WORDS);
  localparam int unsigned PC_W   = $clog2(PROG_WORDS);

  localparam logic [1:0] ST_READ = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_ADDR = 2'd2;
  localparam logic [1:0] ST_WB   = 2'd3;

  logic [1:0]        state_r;
  logic [1:0]        state_nxt;
  tre_uop_t          uop_r;
  logic [31:0]       a_r;
  logic [31:0]       b_r;
  logic [31:0]       rf_mem [32];
  logic [31:0]       rf_vld_r;
  logic [31:0]       dmem [MEM_WORDS];
  logic [31:0]       mem_rd_r;
  logic [MEM_AW-1:0] maddr_r;
  logic [MEM_AW-1:0] clr_cnt_r;
  logic              clr_r;
  logic [PC_W-1:0]   pc_r;
  logic              halt_r;
  logic              out_valid_r;
  tre_out_t          out_data_r;

  logic              memop;
  logic              out_free;
  logic              commit;
  logic              mod_start;
  logic              mod_done;
  logic [MEM_AW-1:0] mod_res;
  logic [31:0]       op2;
  logic [31:0]       rval;
  logic              rw;
  logic              mw;
  logic              taken;
  logic [PC_W-1:0]   pc_inc;
  logic [PC_W-1:0]   npc;
  logic [31:0]       npc32;
  logic [31:0]       maddr32;
  logic              halt_after;
  tre_out_t          res;

  assign memop     = uop_r.is_lw || uop_r.is_sw;
  assign out_free  = !out_valid_r || out_ready;
  assign q_pop     = (state_r == ST_READ) && !q_stat.empty && !clr_r;
  assign mod_start = (state_r == ST_EXEC) && memop && !halt_r;
  assign commit    = out_free && (((state_r == ST_EXEC) && (!memop || halt_r)) ||
                                  (state_r == ST_WB));

  assign out_valid        = out_valid_r;
  assign out_data         = out_data_r;
  assign bk_stat.clearing = clr_r;
  assign bk_stat.idle     = (state_r == ST_READ);

  tre_mod #(.MOD(MEM_WORDS)) u_mod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mod_start),
    .value  (b_r),
    .done   (mod_done),
    .result (mod_res)
  );

  always_comb begin
    op2 = uop_r.use_imm ? uop_r.imm : b_r;
    case (uop_r.alu)
      ALU_IMM:  rval = uop_r.imm;
      ALU_ADD:  rval = a_r + op2;
      ALU_SUB:  rval = a_r - op2;
      ALU_MUL:  rval = a_r * b_r;
      ALU_AND:  rval = a_r & b_r;
      ALU_OR:   rval = a_r | b_r;
      ALU_SLL:  rval = (|uop_r.imm[31:5]) ? '0 : (a_r << uop_r.imm[4:0]);
      ALU_SRA:  rval = (|uop_r.imm[31:5]) ? {32{a_r[31]}} :
                       32'($signed(a_r) >>> uop_r.imm[4:0]);
      ALU_MOV:  rval = a_r;
      ALU_LOAD: rval = mem_rd_r;
      default:  rval = '0;
    endcase
  end

  always_comb begin
    rw     = uop_r.rf_we && !halt_r;
    mw     = uop_r.is_sw && !halt_r;
    // beq: port B holds first_reg, port A second_reg
    taken  = uop_r.is_j || (uop_r.is_beq && (a_r == b_r));
    pc_inc = (pc_r == PC_W'(PROG_WORDS - 1)) ? '0 : pc_r + 1'b1;
    if (halt_r) begin
      npc = pc_r;
    end else if (taken) begin
      npc = PC_W'(uop_r.tgt);
    end else begin
      npc = pc_inc;
    end
    npc32      = 32'(npc);
    maddr32    = 32'(maddr_r);
    halt_after = (rw && (uop_r.dst == HALT_REG)) ? (rval != '0) : halt_r;

    res             = '0;
    res.next_pc     = npc32[9:0];
    res.reg_write   = rw;
    res.reg_index   = rw ? uop_r.dst : '0;
    res.reg_value   = rw ? rval : '0;
    res.mem_write   = mw;
    res.mem_address = mw ? maddr32[9:0] : '0;
    res.mem_value   = mw ? a_r : '0;
    res.halted      = halt_after;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_READ: begin
        if (q_pop) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (mod_start) begin
          state_nxt = ST_ADDR;
        end else if (commit) begin
          state_nxt = ST_READ;
        end
      end
      ST_ADDR: begin
        if (mod_done) begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        if (commit) begin
          state_nxt = ST_READ;
        end
      end
      default: state_nxt = ST_READ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_READ;
      rf_vld_r    <= '0;
      clr_r       <= 1'b1;
      clr_cnt_r   <= '0;
      pc_r        <= '0;
      halt_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == MEM_AW'(MEM_WORDS - 1)) begin
          clr_r <= 1'b0;
        end
      end
      if (cfg_we) begin
        pc_r <= PC_W'(pc_reduce(cfg_wdata, 17'(PROG_WORDS)));
      end else if (commit) begin
        pc_r <= npc;
      end
      if (commit) begin
        halt_r <= halt_after;
        if (rw) begin
          rf_vld_r[uop_r.dst] <= 1'b1;
        end
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // register file: two read ports, registered data
  always_ff @(posedge clk) begin
    if (q_pop) begin
      uop_r <= q_dout;
      a_r   <= rf_vld_r[q_dout.ra] ? rf_mem[q_dout.ra] : '0;
      b_r   <= rf_vld_r[q_dout.rb] ? rf_mem[q_dout.rb] : '0;
    end
    if (commit && rw) begin
      rf_mem[uop_r.dst] <= rval;
    end
    if (commit) begin
      out_data_r <= res;
    end
  end

  // data memory: zeroed by a sweep after reset
  always_ff @(posedge clk) begin
    if (clr_r) begin
      dmem[clr_cnt_r] <= '0;
    end else if (commit && mw) begin
      dmem[maddr_r] <= a_r;
    end
    if ((state_r == ST_ADDR) && mod_done) begin
      maddr_r  <= mod_res;
      mem_rd_r <= dmem[mod_res];
    end
  end

endmodule
`default_nettype wire

@@ sv/toy_risc_instruction_executor.sv @@
// Executes decoded instructions against a 32-entry register file, a data
// memory and a program counter.
// Input channel in_valid/in_ready/in_data carries one decoded instruction
// per item; the output channel out_valid/out_ready/out_data returns one
// result item per instruction, in order.
// cfg_we/cfg_wdata loads the start PC, which also sets the program counter;
// write it only while no item is in flight.
// The front decodes items into a two-entry queue; the back reads the
// register file (state READ), then executes and writes back (state EXEC),
// and takes no new item from the queue until the last one is committed.
// lw and sw add the address reduction (state ADDR) and the memory read or
// write stage (state WB); the reduction is a mask for a power-of-two
// MEM_WORDS and a serial compare-subtract otherwise.
// After reset the data memory is swept to zero, one word per cycle, over
// all MEM_WORDS words; items queue up but none executes until it finishes.
// When out_ready is low the result holds in the output register, the back
// stalls, and in_ready drops once the queue fills.
`default_nettype none
module toy_risc_instruction_executor import tre_pkg::*; #(
  parameter int unsigned MEM_WORDS  = 1024,
  parameter int unsigned PROG_WORDS = 1024
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire tre_in_t    in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output tre_out_t        out_data,
  input  wire logic       cfg_we,
  input  wire logic [9:0] cfg_wdata
);

  tre_q_stat_t  q_stat;
  tre_uop_t     q_din;
  tre_uop_t     q_dout;
  logic         q_push;
  logic         q_pop;
  tre_bk_stat_t bk_stat;

  tre_front #(.PROG_WORDS(PROG_WORDS)) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_din    (q_din)
  );

  tre_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .stat  (q_stat)
  );

  tre_back #(.MEM_WORDS(MEM_WORDS), .PROG_WORDS(PROG_WORDS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .q_dout    (q_dout),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .bk_stat   (bk_stat)
  );

`ifndef SYNTH
  a_no_issue_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.clearing |-> !q_pop)
    else $error("item issued during memory clear");

  a_pop_only_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> bk_stat.idle && !q_stat.empty)
    else $error("queue popped while back busy or empty");

  a_single_write_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.mem_write |-> !out_data.reg_write)
    else $error("result writes both register and memory");

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule
`default_nettype wire

@@ verif/tb_toy_risc_instruction_executor.sv @@
module tb_toy_risc_instruction_executor;
  import tre_pkg::*;

  localparam int DIR_ROWS         = 27;
  localparam int TAIL_ROWS        = 2;
  localparam int CHUNK_ITEMS      = 150;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int LONG_HOLD_AFTER  = 300;

  typedef struct packed {
    tre_in_t  instr;
    logic     typed;
    tre_out_t want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  tre_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  tre_out_t    out_data;
  logic        cfg_we;
  logic [9:0]  cfg_wdata;

  // architectural state as the block should hold it
  logic [31:0] regs_q [32];
  logic [31:0] dmem_q [1024];
  logic [9:0]  pc_q;

  tre_out_t    pending_results [$];
  dir_row_t    dir_rows [DIR_ROWS];
  int          mismatches;
  int          results_seen;
  bit          quiet;
  bit          calm;
  bit          long_hold_done;

  toy_risc_instruction_executor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("toy_risc_instruction_executor verification failed");
    $finish;
  end

  function automatic tre_in_t instr(input logic [4:0] op, input logic [4:0] rd,
                                    input logic [4:0] rs, input logic [4:0] rt,
                                    input logic [31:0] imm, input logic [9:0] tgt);
    tre_in_t it;
    it.operation   = op;
    it.first_reg   = rd;
    it.second_reg  = rs;
    it.third_reg   = rt;
    it.immediate   = imm;
    it.jump_target = tgt;
    return it;
  endfunction

  function automatic tre_out_t outcome(input logic [9:0] npc, input logic rw,
                                       input logic [4:0] ri, input logic [31:0] rv,
                                       input logic mw, input logic [9:0] ma,
                                       input logic [31:0] mv, input logic h);
    tre_out_t r;
    r.next_pc     = npc;
    r.reg_write   = rw;
    r.reg_index   = ri;
    r.reg_value   = rv;
    r.mem_write   = mw;
    r.mem_address = ma;
    r.mem_value   = mv;
    r.halted      = h;
    return r;
  endfunction

  function automatic logic writes_reg(input logic [4:0] op);
    return (op == OP_LI) || (op == OP_EXIT) || (op >= OP_ADD && op <= OP_LA);
  endfunction

  // executes one instruction on the local state and returns its result item
  function automatic tre_out_t execute_instr(input tre_in_t it);
    logic [4:0]  op;
    logic [4:0]  dst;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] sh;
    logic [31:0] val;
    logic [9:0]  nxt;
    logic        rw;
    logic        mw;
    tre_out_t    r;
    op  = it.operation;
    dst = it.first_reg;
    a   = regs_q[it.second_reg];
    b   = regs_q[it.third_reg];
    sh  = it.immediate;
    nxt = pc_q + 10'd1;
    rw  = 1'b0;
    mw  = 1'b0;
    val = '0;
    r   = '0;
    if (regs_q[HALT_REG] != '0) begin
      nxt = pc_q;
      op  = OP_NOP;
    end
    case (op)
      OP_LI, OP_LA: begin
        rw  = 1'b1;
        val = it.immediate;
      end
      OP_EXIT: begin
        rw  = 1'b1;
        dst = HALT_REG;
        val = 32'd1;
      end
      OP_J: nxt = it.jump_target;
      OP_BEQ: begin
        if (regs_q[it.first_reg] == a) nxt = it.jump_target;
      end
      OP_ADD:  begin rw = 1'b1; val = a + b; end
      OP_ADDI: begin rw = 1'b1; val = a + it.immediate; end
      OP_SUB:  begin rw = 1'b1; val = a - b; end
      OP_SUBI: begin rw = 1'b1; val = a - it.immediate; end
      OP_MUL:  begin rw = 1'b1; val = a * b; end
      OP_AND:  begin rw = 1'b1; val = a & b; end
      OP_OR:   begin rw = 1'b1; val = a | b; end
      OP_SLL: begin
        rw  = 1'b1;
        val = (sh >= 32) ? 32'd0 : (a << sh[4:0]);
      end
      OP_SRL: begin
        rw = 1'b1;
        if (sh >= 32) val = {32{a[31]}};
        else val = $signed(a) >>> sh[4:0];
      end
      OP_MV: begin rw = 1'b1; val = a; end
      OP_LW: begin rw = 1'b1; val = dmem_q[b[9:0]]; end
      OP_SW: mw = 1'b1;
      default: ;
    endcase
    if (mw) begin
      dmem_q[b[9:0]] = regs_q[it.first_reg];
      r.mem_write    = 1'b1;
      r.mem_address  = b[9:0];
      r.mem_value    = regs_q[it.first_reg];
    end
    if (rw) begin
      regs_q[dst] = val;
      r.reg_write = 1'b1;
      r.reg_index = dst;
      r.reg_value = val;
    end
    pc_q      = nxt;
    r.next_pc = nxt;
    r.halted  = (regs_q[HALT_REG] != '0);
    return r;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'($urandom_range(0, 40));
      1: return -32'($urandom_range(1, 40));
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 32'hffffffff;
          default: return 32'h0;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // pointers cluster at both ends of memory so loads see earlier stores;
  // the upper bits exercise the address wrap
  function automatic logic [31:0] pick_addr();
    logic [31:0] w;
    w = $urandom();
    if ($urandom_range(0, 1)) w[9:0] = 10'($urandom_range(0, 15));
    else w[9:0] = 10'(1023 - $urandom_range(0, 15));
    case ($urandom_range(0, 3))
      0: w[31:10] = '1;
      1: ;
      default: w[31:10] = '0;
    endcase
    return w;
  endfunction

  // never r31: a nonzero write there halts the block for the rest of the run
  function automatic logic [4:0] pick_dst();
    return 5'($urandom_range(0, 30));
  endfunction

  task automatic check_result(input tre_out_t got);
    tre_out_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      $error("result item with nothing outstanding: %h", got);
      mismatches++;
    end else begin
      want = pending_results.pop_front();
      if (got.next_pc !== want.next_pc) begin
        $error("next_pc: expected %0d, got %0d", want.next_pc, got.next_pc);
        mismatches++;
      end
      if (got.reg_write !== want.reg_write) begin
        $error("reg_write: expected %0d, got %0d", want.reg_write, got.reg_write);
        mismatches++;
      end
      if (got.reg_index !== want.reg_index) begin
        $error("reg_index: expected %0d, got %0d", want.reg_index, got.reg_index);
        mismatches++;
      end
      if (got.reg_value !== want.reg_value) begin
        $error("reg_value: expected %0d, got %0d", want.reg_value, got.reg_value);
        mismatches++;
      end
      if (got.mem_write !== want.mem_write) begin
        $error("mem_write: expected %0d, got %0d", want.mem_write, got.mem_write);
        mismatches++;
      end
      if (got.mem_address !== want.mem_address) begin
        $error("mem_address: expected %0d, got %0d", want.mem_address, got.mem_address);
        mismatches++;
      end
      if (got.mem_value !== want.mem_value) begin
        $error("mem_value: expected %0d, got %0d", want.mem_value, got.mem_value);
        mismatches++;
      end
      if (got.halted !== want.halted) begin
        $error("halted: expected %0d, got %0d", want.halted, got.halted);
        mismatches++;
      end
    end
  endtask

  task automatic maybe_idle();
    if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic send_item(input tre_in_t it, input logic typed, input tre_out_t want);
    tre_out_t predicted;
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = execute_instr(it);
    pending_results = {pending_results, (typed ? want : predicted)};
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_start_pc(input logic [9:0] value);
    drain();
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    pc_q = value;
  endtask

  // mostly short programs (store/load, compare/branch, arithmetic on
  // fresh operands) with random content, plus raw noise items
  task automatic run_programs(input int count);
    tre_in_t     batch [$];
    tre_in_t     it;
    logic [63:0] raw;
    logic [31:0] v;
    logic [4:0]  ra;
    logic [4:0]  rb;
    int          sent;
    int          kind;
    sent = 0;
    while (sent < count) begin
      batch.delete();
      ra   = pick_dst();
      rb   = pick_dst();
      raw  = {$urandom(), $urandom()};
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        batch = {batch, instr($urandom_range(0, 1) ? OP_LA : OP_LI, ra, raw[4:0], raw[9:5],
                              pick_addr(), raw[19:10])};
        batch = {batch, instr(OP_SW, raw[24:20], raw[29:25], ra, $urandom(), raw[39:30])};
        if (raw[40]) begin
          batch = {batch, instr(OP_MV, rb, ra, raw[45:41], pick_word(), raw[55:46])};
        end else begin
          rb = ra;
        end
        batch = {batch, instr(OP_LW, pick_dst(), raw[60:56], rb, $urandom(), raw[9:0])};
      end else if (kind < 5) begin
        v = pick_word();
        batch = {batch, instr(OP_LI, ra, raw[4:0], raw[9:5], v, raw[19:10])};
        batch = {batch, instr(OP_LI, rb, raw[24:20], raw[29:25],
                              raw[40] ? v : v ^ (32'd1 << raw[36:32]), raw[50:41])};
        batch = {batch, instr(OP_BEQ, ra, rb, raw[55:51], $urandom(), raw[61:52])};
      end else if (kind < 8) begin
        batch = {batch, instr(OP_LI, ra, raw[4:0], raw[9:5], pick_word(), raw[19:10])};
        batch = {batch, instr(OP_LI, rb, raw[24:20], raw[29:25], pick_word(), raw[39:30])};
        batch = {batch, instr(5'($urandom_range(OP_ADD, OP_MV)), pick_dst(), ra, rb,
                              pick_word(), raw[49:40])};
      end else begin
        it = raw[61:0];
        if (it.operation == OP_EXIT) it.operation = OP_NOP;
        if (writes_reg(it.operation)) it.first_reg = pick_dst();
        batch = {batch, it};
      end
      foreach (batch[i]) begin
        maybe_idle();
        send_item(batch[i], 1'b0, '0);
        sent++;
        if (sent % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      end
    end
  endtask

  // result side: random stalls plus one long hold-off to back up the input
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) check_result(out_data);
      if (stall_left > 0) begin
        stall_left--;
      end else if (!quiet && !long_hold_done && results_seen >= LONG_HOLD_AFTER) begin
        long_hold_done = 1'b1;
        stall_left     = LONG_HOLD_CYCLES;
      end else if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13);
      end
      out_ready <= (stall_left == 0);
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    mismatches     = 0;
    results_seen   = 0;
    quiet          = 1'b0;
    calm           = 1'b0;
    long_hold_done = 1'b0;
    foreach (regs_q[i]) regs_q[i] = '0;
    foreach (dmem_q[i]) dmem_q[i] = '0;
    pc_q = '0;

    // rows 0..18 run straight from pc 0, so next_pc is the row number plus one
    dir_rows[0]  = '{instr(OP_NOP, 5'd0, 5'd0, 5'd0, 32'h0, 10'd0), 1'b1,
                     outcome(10'd1, 1'b0, 5'd0, 32'h0, 1'b0, 10'd0, 32'h0, 1'b0)};
    dir_rows[1]  = '{instr(OP_LI, 5'd1, 5'd0, 5'd0, 32'h7fffffff, 10'd1023), 1'b1,
                     outcome(10'd2, 1'b1, 5'd1, 32'h7fffffff, 1'b0, 10'd0, 32'h0, 1'b0)};
    dir_rows[2]  = '{instr(OP_LI, 5'd2, 5'd0, 5'd0, 32'h80000000, 10'd0), 1'b1,
                     outcome(10'd3, 1'b1, 5'd2, 32'h80000000, 1'b0, 10'd0, 32'h0, 1'b0)};
    // r0 is an ordinary register
    dir_rows[3]  = '{instr(OP_LI, 5'd0, 5'd0, 5'd0, 32'hffffffff, 10'd0), 1'b1,
                     outcome(10'd4, 1'b1, 5'd0, 32'hffffffff, 1'b0, 10'd0, 32'h0, 1'b0)};
    dir_rows[4]  = '{instr(OP_ADD, 5'd3, 5'd1, 5'd0, 32'h0, 10'd0), 1'b0, '0};
    dir_rows[5]  = '{instr(OP_ADDI, 5'd4, 5'd1, 5'd0, 32'h1, 10'd0), 1'b0, '0};
    dir_rows[6]  = '{instr(OP_SUB, 5'd5, 5'd2, 5'd1, 32'h0, 10'd0), 1'b0, '0};
    dir_rows[7]  = '{instr(OP_SUBI, 5'd6, 5'd2, 5'd0, 32'h1, 10'd0), 1'b0, '0};
    dir_rows[8]  = '{instr(OP_MUL, 5'd7, 5'd1, 5'd1, 32'h0, 10'd0), 1'b0, '0};
    dir_rows[9]  = '{instr(OP_AND, 5'd8, 5'd0, 5'd2, 32'h0, 10'd0), 1'b0, '0};
    dir_rows[10] = '{instr(OP_OR, 5'd9, 5'd1, 5'd2, 32'h0, 10'd0), 1'b0, '0};
    dir_rows[11] = '{instr(OP_SLL, 5'd10, 5'd0, 5'd0, 32'd31, 10'd0), 1'b1,
                     outcome(10'd12, 1'b1, 5'd10, 32'h80000000, 1'b0, 10'd0, 32'h0, 1'b0)};
    // shift by 32 or more clears
    dir_rows[12] = '{instr(OP_SLL, 5'd11, 5'd0, 5'd0, 32'd32, 10'd0), 1'b1,
                     outcome(10'd13, 1'b1, 5'd11, 32'h0, 1'b0, 10'd0, 32'h0, 1'b0)};
    dir_rows[13] = '{instr(OP_SRL, 5'd12, 5'd2, 5'd0, 32'd4, 10'd0), 1'b0, '0};
    // negative amount reads as huge: sign fill
    dir_rows[14] = '{instr(OP_SRL, 5'd13, 5'd2, 5'd0, 32'hffffffff, 10'd0), 1'b1,
                     outcome(10'd15, 1'b1, 5'd13, 32'hffffffff, 1'b0, 10'd0, 32'h0, 1'b0)};
    dir_rows[15] = '{instr(OP_MV, 5'd14, 5'd2, 5'd0, 32'h0, 10'd0), 1'b0, '0};
    dir_rows[16] = '{instr(OP_LA, 5'd15, 5'd0, 5'd0, 32'h3ff, 10'd0), 1'b0, '0};
    dir_rows[17] = '{instr(OP_SW, 5'd1, 5'd0, 5'd15, 32'h0, 10'd0), 1'b1,
                     outcome(10'd18, 1'b0, 5'd0, 32'h0, 1'b1, 10'd1023, 32'h7fffffff, 1'b0)};
    // address from r0 = all ones wraps onto the word just stored
    dir_rows[18] = '{instr(OP_LW, 5'd16, 5'd0, 5'd0, 32'h0, 10'd0), 1'b1,
                     outcome(10'd19, 1'b1, 5'd16, 32'h7fffffff, 1'b0, 10'd0, 32'h0, 1'b0)};
    dir_rows[19] = '{instr(OP_BEQ, 5'd1, 5'd1, 5'd0, 32'h0, 10'd5), 1'b0, '0};
    dir_rows[20] = '{instr(OP_BEQ, 5'd1, 5'd2, 5'd0, 32'h0, 10'd1000), 1'b0, '0};
    dir_rows[21] = '{instr(OP_J, 5'd0, 5'd0, 5'd0, 32'h0, 10'd1023), 1'b0, '0};
    // pc wraps past the top of program space
    dir_rows[22] = '{instr(OP_NOP, 5'd0, 5'd0, 5'd0, 32'h0, 10'd0), 1'b0, '0};
    // unused opcode, every field at its top value
    dir_rows[23] = '{instr(5'd31, 5'd31, 5'd31, 5'd31, 32'hffffffff, 10'd1023), 1'b0, '0};
    dir_rows[24] = '{instr(OP_LI, 5'd31, 5'd0, 5'd0, 32'h0, 10'd0), 1'b0, '0};
    // tail: halt, then an instruction that must be ignored
    dir_rows[25] = '{instr(OP_EXIT, 5'd4, 5'd4, 5'd4, 32'h5, 10'd7), 1'b0, '0};
    dir_rows[26] = '{instr(OP_LI, 5'd3, 5'd0, 5'd0, 32'h5, 10'd0), 1'b0, '0};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS - TAIL_ROWS; i++) begin
      maybe_idle();
      send_item(dir_rows[i].instr, dir_rows[i].typed, dir_rows[i].want);
    end

    write_start_pc(10'd1023);
    run_programs(CHUNK_ITEMS);
    write_start_pc(10'd0);
    run_programs(CHUNK_ITEMS);
    write_start_pc(10'($urandom()));
    run_programs(CHUNK_ITEMS);
    write_start_pc(10'd512);
    run_programs(CHUNK_ITEMS);
    write_start_pc(10'($urandom()));
    run_programs(CHUNK_ITEMS);
    quiet = 1'b1;
    write_start_pc(10'd1022);
    run_programs(CHUNK_ITEMS);

    for (int i = DIR_ROWS - TAIL_ROWS; i < DIR_ROWS; i++) begin
      send_item(dir_rows[i].instr, dir_rows[i].typed, dir_rows[i].want);
    end
    // start_pc still reloads the pc while halted
    write_start_pc(10'($urandom()));
    send_item(instr(OP_SW, 5'd31, 5'd0, 5'd0, 32'h0, 10'd0), 1'b0, '0);

    drain();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("toy_risc_instruction_executor verification clean");
    end else begin
      $display("toy_risc_instruction_executor verification failed");
    end
    $finish;
  end

endmodule
